// ----- hw/rtl/sfx_pkg.sv -----
// shared types, constants and the exp2 table builder for the softmax block
// no dependencies
package sfx_pkg;

   localparam int PLANE_DEPTH_DEF    = 64;
   localparam int EXP_TABLE_BITS_DEF = 8;

   localparam logic FUNC_FWD = 1'b0;
   localparam logic FUNC_BWD = 1'b1;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [63:0] LN2_Q32   = 64'd2977044472;
   localparam logic [16:0] ONE_Q16   = 17'd65536;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAX_RD,
      ST_MAX_CMP,
      ST_EXP_RD,
      ST_EXP_MUL,
      ST_EXP_ACC,
      ST_DIV_RD,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_OUT,
      ST_GRAD_RD,
      ST_GRAD_W,
      ST_GRAD_M,
      ST_GRAD_OUT
   } state_type;

   typedef struct packed {
      logic load_sample;
      logic take_grad;
      logic max_step;
      logic exp_mul;
      logic exp_acc;
      logic div_init;
      logic div_step;
      logic div_out;
      logic sel_grad;
      logic grad_w;
      logic grad_m;
      logic grad_out;
   } cmd_type;

   typedef struct packed {
      logic load_at_max;
      logic walk_last;
      logic div_done;
   } status_type;

   // 2^-u in q1.16 from u in q0.16, evaluated at elaboration only
   function automatic logic [16:0] exp2neg_q16(input logic [15:0] u);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] acc;
      y    = ({48'd0, u} * LN2_Q32) >> 16;
      term = 64'd1 << 32;
      acc  = term;
      for (int k = 1; k <= 13; k++) begin
         term = ((term * y) >> 32) / 64'(k);
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return 17'((acc + 64'd32768) >> 16);
   endfunction

endpackage

// ----- hw/rtl/softmax_plane_fwd_bwd.sv -----
// Forward samples (req_func 0) are accepted back to back while busy is low. The sample
// that ends a plane (req_last_in, or the plane is full) starts the softmax pass:
// over the n samples, a read and a compare for the maximum scan, then a read, a
// multiply and an accumulate for exp and sum, then a read, an init, the bit-serial
// divider (one quotient bit a cycle) and an output, with busy high throughout and
// one probability strobed on rsp_strobe per sample. A gradient item (req_func 1)
// holds busy high through the probability read and two registered multiplies.
// Results last one cycle on rsp_strobe; the receiver cannot stall them.
// top level; depends on sfx_pkg, sfx_ctrl, sfx_datapath
module softmax_plane_fwd_bwd #(
   parameter int PLANE_DEPTH    = sfx_pkg::PLANE_DEPTH_DEF,
   parameter int EXP_TABLE_BITS = sfx_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic signed [15:0] req_value,
   input  logic               req_last_in,
   output logic               rsp_strobe,
   output logic signed [16:0] rsp_result_value,
   output logic               rsp_is_backward,
   output logic               rsp_last_out
);

   sfx_pkg::cmd_type    cmd;
   sfx_pkg::status_type status;

   sfx_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_func    (req_func),
      .req_last_in (req_last_in),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   sfx_datapath #(
      .PLANE_DEPTH    (PLANE_DEPTH),
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_is_backward  (rsp_is_backward),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// ----- hw/rtl/sfx_ctrl.sv -----
// sequencing state machine for the softmax block
// depends on sfx_pkg
module sfx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_func,
   input  logic                  req_last_in,
   input  sfx_pkg::status_type   status,
   output logic                  busy,
   output sfx_pkg::cmd_type      cmd
);

   sfx_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         sfx_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_func == sfx_pkg::FUNC_BWD) begin
                  cmd.take_grad = 1'b1;
                  state_in      = sfx_pkg::ST_GRAD_RD;
               end else begin
                  cmd.load_sample = 1'b1;
                  if (req_last_in || status.load_at_max) begin
                     state_in = sfx_pkg::ST_MAX_RD;
                  end
               end
            end
         end
         sfx_pkg::ST_MAX_RD: state_in = sfx_pkg::ST_MAX_CMP;
         sfx_pkg::ST_MAX_CMP: begin
            cmd.max_step = 1'b1;
            state_in = status.walk_last ? sfx_pkg::ST_EXP_RD : sfx_pkg::ST_MAX_RD;
         end
         sfx_pkg::ST_EXP_RD: state_in = sfx_pkg::ST_EXP_MUL;
         sfx_pkg::ST_EXP_MUL: begin
            cmd.exp_mul = 1'b1;
            state_in    = sfx_pkg::ST_EXP_ACC;
         end
         sfx_pkg::ST_EXP_ACC: begin
            cmd.exp_acc = 1'b1;
            state_in = status.walk_last ? sfx_pkg::ST_DIV_RD : sfx_pkg::ST_EXP_RD;
         end
         sfx_pkg::ST_DIV_RD: state_in = sfx_pkg::ST_DIV_INIT;
         sfx_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = sfx_pkg::ST_DIV_STEP;
         end
         sfx_pkg::ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = sfx_pkg::ST_DIV_OUT;
            end
         end
         sfx_pkg::ST_DIV_OUT: begin
            cmd.div_out = 1'b1;
            state_in = status.walk_last ? sfx_pkg::ST_IDLE : sfx_pkg::ST_DIV_RD;
         end
         sfx_pkg::ST_GRAD_RD: begin
            cmd.sel_grad = 1'b1;
            state_in     = sfx_pkg::ST_GRAD_W;
         end
         sfx_pkg::ST_GRAD_W: begin
            cmd.grad_w = 1'b1;
            state_in   = sfx_pkg::ST_GRAD_M;
         end
         sfx_pkg::ST_GRAD_M: begin
            cmd.grad_m = 1'b1;
            state_in   = sfx_pkg::ST_GRAD_OUT;
         end
         sfx_pkg::ST_GRAD_OUT: begin
            cmd.grad_out = 1'b1;
            state_in     = sfx_pkg::ST_IDLE;
         end
         default: state_in = sfx_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/sfx_datapath.sv -----
// stores, exp table, serial divider and gradient multipliers
// depends on sfx_pkg
module sfx_datapath #(
   parameter int PLANE_DEPTH    = sfx_pkg::PLANE_DEPTH_DEF,
   parameter int EXP_TABLE_BITS = sfx_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfx_pkg::cmd_type      cmd,
   input  logic signed [15:0]    req_value,
   output sfx_pkg::status_type   status,
   output logic                  rsp_strobe,
   output logic signed [16:0]    rsp_result_value,
   output logic                  rsp_is_backward,
   output logic                  rsp_last_out
);

   localparam int CW = $clog2(PLANE_DEPTH + 1);
   localparam int AW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
   localparam int SW = $clog2(PLANE_DEPTH) + 17;
   localparam int NW = SW + 17;
   localparam int TN = 2 ** EXP_TABLE_BITS;

   logic [15:0]        sample_mem [PLANE_DEPTH];
   logic [16:0]        prob_mem   [PLANE_DEPTH];
   logic [16:0]        exp_lut    [TN];

   logic [CW-1:0]      load_cnt_ff, load_cnt_in;
   logic [CW-1:0]      walk_ff, walk_in;
   logic [CW-1:0]      grad_ff, grad_in;
   logic [CW-1:0]      plane_len_ff, plane_len_in;
   logic [CW-1:0]      len;
   logic [AW-1:0]      rd_addr;

   logic signed [15:0] samp_rd_ff;
   logic [16:0]        prob_rd_ff;
   logic signed [15:0] max_ff, max_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [24:0]        t_ff, t_in;
   logic [16:0]        e_val;
   logic [SW-1:0]      divisor;
   logic [NW-1:0]      num_ff, num_in;
   logic [SW-1:0]      rem_ff, rem_in;
   logic [SW:0]        trial;
   logic [16:0]        q_ff, q_in;
   logic [4:0]         bitc_ff, bitc_in;
   logic [15:0]        p_sat;

   logic signed [15:0] gval_ff;
   logic [32:0]        w_ff;
   logic [15:0]        abs_ff;
   logic [48:0]        mag_ff;
   logic [49:0]        mag_rnd;
   logic [17:0]        r_mag;
   logic signed [16:0] g_res;
   logic [16:0]        d_wide;
   logic [16:0]        one_minus;

   logic               strobe_ff, strobe_in;
   logic signed [16:0] res_ff, res_in;
   logic               back_ff, back_in;
   logic               last_ff, last_in;
   logic               grad_last;

   for (genvar gi = 0; gi < TN; gi++) begin : g_lut
      assign exp_lut[gi] = sfx_pkg::exp2neg_q16(16'(gi << (16 - EXP_TABLE_BITS)));
   end

   assign len       = (plane_len_ff == '0) ? CW'(PLANE_DEPTH) : plane_len_ff;
   assign grad_last = (grad_ff == len - CW'(1));
   assign rd_addr   = cmd.sel_grad ? grad_ff[AW-1:0] : walk_ff[AW-1:0];

   assign status.load_at_max = (load_cnt_ff == CW'(PLANE_DEPTH - 1));
   assign status.walk_last   = (walk_ff == load_cnt_ff - CW'(1));
   assign status.div_done    = (bitc_ff == 5'd0);

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_mem[load_cnt_ff[AW-1:0]] <= req_value;
      end
      samp_rd_ff <= sample_mem[walk_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_acc) begin
         prob_mem[walk_ff[AW-1:0]] <= e_val;
      end else if (cmd.div_out) begin
         prob_mem[walk_ff[AW-1:0]] <= {1'b0, p_sat};
      end
      prob_rd_ff <= prob_mem[rd_addr];
   end

   // forward arithmetic
   always_comb begin
      d_wide  = 17'({samp_rd_ff[15], samp_rd_ff});
      d_wide  = 17'({max_ff[15], max_ff}) - d_wide;
      t_in    = t_ff;
      if (cmd.exp_mul) begin
         t_in = 25'(((34'(d_wide[15:0]) * 34'(sfx_pkg::LOG2E_Q16)) + 34'd128) >> 8);
      end
      if (t_ff[24:16] > 9'd16) begin
         e_val = '0;
      end else begin
         e_val = exp_lut[t_ff[15 -: EXP_TABLE_BITS]] >> t_ff[20:16];
      end

      max_in = max_ff;
      sum_in = sum_ff;
      if (cmd.max_step) begin
         sum_in = '0;
         if (walk_ff == '0 || samp_rd_ff > max_ff) begin
            max_in = samp_rd_ff;
         end
      end
      if (cmd.exp_acc) begin
         sum_in = sum_ff + SW'(e_val);
      end

      divisor = (sum_ff == '0) ? SW'(1) : sum_ff;
      trial   = {rem_ff, num_ff[16]};
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      bitc_in = bitc_ff;
      if (cmd.div_init) begin
         num_in  = (NW'(prob_rd_ff) << 16) + NW'(divisor >> 1);
         rem_in  = SW'(num_in >> 17);
         bitc_in = 5'd16;
      end else if (cmd.div_step) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = SW'(trial - {1'b0, divisor});
            q_in   = {q_ff[15:0], 1'b1};
         end else begin
            rem_in = trial[SW-1:0];
            q_in   = {q_ff[15:0], 1'b0};
         end
         bitc_in = (bitc_ff == 5'd0) ? 5'd0 : bitc_ff - 5'd1;
      end
      p_sat = q_ff[16] ? 16'hFFFF : q_ff[15:0];
   end

   always_ff @(posedge clock) begin
      max_ff  <= max_in;
      sum_ff  <= sum_in;
      t_ff    <= t_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      bitc_ff <= bitc_in;
   end

   // backward arithmetic
   assign one_minus = sfx_pkg::ONE_Q16 - {1'b0, prob_rd_ff[15:0]};
   assign mag_rnd   = 50'(mag_ff) + (50'd1 << 31);
   assign r_mag     = mag_rnd[49:32];

   always_comb begin
      if (gval_ff < 0) begin
         g_res = (r_mag > 18'd32768) ? -17'sd32768 : -$signed({1'b0, r_mag[15:0]});
      end else begin
         g_res = (r_mag > 18'd32767) ? 17'sd32767 : $signed({1'b0, r_mag[15:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_grad) begin
         gval_ff <= req_value;
      end
      if (cmd.grad_w) begin
         w_ff   <= 33'(prob_rd_ff[15:0]) * 33'(one_minus);
         abs_ff <= (gval_ff < 0) ? 16'(-17'(gval_ff)) : 16'(gval_ff);
      end
      if (cmd.grad_m) begin
         mag_ff <= 49'(abs_ff) * 49'(w_ff);
      end
   end

   // indices and counters
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      walk_in      = walk_ff;
      grad_in      = grad_ff;
      plane_len_in = plane_len_ff;
      if (cmd.load_sample) begin
         load_cnt_in = load_cnt_ff + CW'(1);
      end
      if (cmd.max_step || cmd.exp_acc || cmd.div_out) begin
         walk_in = status.walk_last ? '0 : walk_ff + CW'(1);
      end
      if (cmd.div_out && status.walk_last) begin
         plane_len_in = load_cnt_ff;
         load_cnt_in  = '0;
         grad_in      = '0;
      end
      if (cmd.grad_out) begin
         grad_in = grad_last ? '0 : grad_ff + CW'(1);
      end
   end

   always_comb begin
      strobe_in = cmd.div_out || cmd.grad_out;
      res_in    = res_ff;
      back_in   = back_ff;
      last_in   = last_ff;
      if (cmd.div_out) begin
         res_in  = $signed({1'b0, p_sat});
         back_in = 1'b0;
         last_in = status.walk_last;
      end else if (cmd.grad_out) begin
         res_in  = g_res;
         back_in = 1'b1;
         last_in = grad_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff  <= '0;
         walk_ff      <= '0;
         grad_ff      <= '0;
         plane_len_ff <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         load_cnt_ff  <= load_cnt_in;
         walk_ff      <= walk_in;
         grad_ff      <= grad_in;
         plane_len_ff <= plane_len_in;
         strobe_ff    <= strobe_in;
      end
      res_ff  <= res_in;
      back_ff <= back_in;
      last_ff <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = res_ff;
   assign rsp_is_backward  = back_ff;
   assign rsp_last_out     = last_ff;

`ifndef SYNTH
   a_grad_in_range: assert property (@(posedge clock) disable iff (reset)
      grad_ff < len) else $error("gradient index beyond plane length");
   a_load_bounded: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff <= CW'(PLANE_DEPTH)) else $error("load count overflow");
   a_div_complete: assert property (@(posedge clock) disable iff (reset)
      cmd.div_out |-> bitc_ff == 5'd0) else $error("quotient emitted early");
`endif

endmodule
